// File: design/framed_packet_receiver_unit_assert.svh
// Assertion macros for the framed packet receiver unit.
// Included by the module that carries concurrent checks; no other dependencies.
`ifndef FRAMED_PACKET_RECEIVER_UNIT_ASSERT_SVH
`define FRAMED_PACKET_RECEIVER_UNIT_ASSERT_SVH

`ifndef SYNTH
// Check that holds outside reset.
`define FRP_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("frp assertion failed");
// Check that holds at every edge, reset included.
`define FRP_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("frp assertion failed");
`else
`define FRP_ASSERT(label, clk, rst, prop)
`define FRP_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// File: design/frp_pkg.sv
// Shared types, codes and checksum helper for the framed packet receiver.
// No dependencies.
`timescale 1ns / 1ps

package frp_pkg;

  localparam int PAYLOAD_DEPTH_DEF = 256;
  localparam int CFG_INDEX_W       = 1;
  localparam int CFG_DATA_W        = 8;

  localparam logic [7:0] SUM_BASE        = 8'hFF;
  localparam logic [7:0] FIRST_SYNC_RST  = 8'hC2;
  localparam logic [7:0] SECOND_SYNC_RST = 8'h53;

  typedef enum logic [2:0] {
    PH_SYNC1   = 3'd0,
    PH_SYNC2   = 3'd1,
    PH_CLASS   = 3'd2,
    PH_ID      = 3'd3,
    PH_LENGTH  = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_CHECK1  = 3'd6,
    PH_CHECK2  = 3'd7
  } frp_phase_t;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2
  } frp_kind_t;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_ACCEPT = 2'd1,
    EV_REJECT = 2'd2
  } frp_event_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FIRST_SYNC  = 1'd0,
    CFG_SECOND_SYNC = 1'd1
  } frp_cfg_idx_t;

  typedef struct packed {
    logic [7:0] hi;
    logic [7:0] lo;
  } frp_sums_t;

  // Payload store write request; addr is the full payload offset.
  typedef struct packed {
    logic       we;
    logic [7:0] addr;
    logic [7:0] data;
  } frp_wr_t;

  // Held header and ready flag after the latest item.
  typedef struct packed {
    logic       ready;
    logic [7:0] cls;
    logic [7:0] id;
    logic [7:0] length;
  } frp_status_t;

  // One Fletcher step: each sum wraps by 255 when it passes 255.
  function automatic frp_sums_t frp_sum_step(input frp_sums_t s, input logic [7:0] b);
    logic [8:0] lo;
    logic [8:0] hi;
    frp_sums_t  r;
    lo = {1'b0, s.lo} + {1'b0, b};
    if (lo > {1'b0, SUM_BASE}) begin
      lo = lo - {1'b0, SUM_BASE};
    end
    hi = {1'b0, s.hi} + {1'b0, lo[7:0]};
    if (hi > {1'b0, SUM_BASE}) begin
      hi = hi - {1'b0, SUM_BASE};
    end
    r.lo = lo[7:0];
    r.hi = hi[7:0];
    return r;
  endfunction

endpackage

// File: design/frp_ifs.sv
// Valid/ready channel interfaces for request and response items.
// No dependencies.
`timescale 1ns / 1ps

interface frp_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] rx_byte;
  logic [7:0] read_index;

  modport source (output valid, kind, rx_byte, read_index, input ready);
  modport sink   (input valid, kind, rx_byte, read_index, output ready);
endinterface

interface frp_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] frame_event;
  logic       frame_ready;
  logic [7:0] frame_class;
  logic [7:0] frame_id;
  logic [7:0] frame_length;
  logic [7:0] read_data;

  modport source (output valid, frame_event, frame_ready, frame_class, frame_id,
                  frame_length, read_data, input ready);
  modport sink   (input valid, frame_event, frame_ready, frame_class, frame_id,
                  frame_length, read_data, output ready);
endinterface

// File: design/framed_packet_receiver_unit.sv
// Top level of the framed packet receiver: channel handshake and result register.
// Depends on frp_pkg, frp_ifs, frp_parser, frp_store and the assertion header.
//
// Channel   Role      Carries
// req       sink      kind, rx_byte, read_index
// rsp       source    frame_event, frame_ready, frame_class, frame_id,
//                     frame_length, read_data
// cfg_*     write     first / second sync byte
//
// One item per cycle while rsp is not stalled; results show the cycle after the take.
// The result register, the parser registers and the store read all load on that edge.
// req.ready is high whenever the result register is empty or being drained.
// Reset (rst, synchronous) clears parser state and restores the default sync
// bytes; the payload store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`include "framed_packet_receiver_unit_assert.svh"

module framed_packet_receiver_unit #(
  parameter int PAYLOAD_DEPTH = frp_pkg::PAYLOAD_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  frp_req_if.sink                         req,
  frp_rsp_if.source                       rsp,
  input  logic                            cfg_we,
  input  logic [frp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [frp_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic                  take;
  logic                  valid_q;
  frp_pkg::frp_event_t   ev;
  frp_pkg::frp_event_t   ev_q;
  frp_pkg::frp_wr_t      wr;
  frp_pkg::frp_status_t  status;
  logic [7:0]            rd_data;

  assign req.ready = !valid_q || rsp.ready;
  assign take      = req.valid && req.ready;

  frp_parser #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .kind      (req.kind),
    .rx_byte   (req.rx_byte),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ev        (ev),
    .wr        (wr),
    .status    (status)
  );

  frp_store #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .wr       (wr),
    .rd_en    (req.kind == frp_pkg::KIND_READ),
    .rd_index (req.read_index),
    .rd_data  (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (rsp.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ev_q <= ev;
    end
  end

  // Parser registers only move on an accepted item, so they match the held result.
  assign rsp.valid        = valid_q;
  assign rsp.frame_event  = ev_q;
  assign rsp.frame_ready  = status.ready;
  assign rsp.frame_class  = status.cls;
  assign rsp.frame_id     = status.id;
  assign rsp.frame_length = status.length;
  assign rsp.read_data    = rd_data;

  `FRP_ASSERT(a_take_fills_result, clk, rst, take |=> valid_q)
  `FRP_ASSERT(a_stall_blocks_req, clk, rst, (valid_q && !rsp.ready) |-> !req.ready)
  `FRP_ASSERT(a_clear_drops_ready, clk, rst,
    (take && req.kind == frp_pkg::KIND_CLEAR) |=> !status.ready)
  `FRP_ASSERT(a_ready_rises_on_accept, clk, rst,
    $rose(status.ready) |-> (valid_q && ev_q == frp_pkg::EV_ACCEPT))
  `FRP_ASSERT(a_accept_shows_ready, clk, rst,
    (valid_q && ev_q == frp_pkg::EV_ACCEPT) |-> status.ready)

endmodule

// File: design/frp_store.sv
// Payload store: single-port-write, registered-read memory of payload bytes.
// Depends on frp_pkg.
`timescale 1ns / 1ps

module frp_store #(
  parameter int PAYLOAD_DEPTH = frp_pkg::PAYLOAD_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           take,
  input  frp_pkg::frp_wr_t wr,
  input  logic           rd_en,
  input  logic [7:0]     rd_index,
  output logic [7:0]     rd_data
);

  localparam int ADDR_W = $clog2(PAYLOAD_DEPTH);
  localparam logic [8:0] DEPTH = 9'(PAYLOAD_DEPTH);

  logic [7:0] mem [PAYLOAD_DEPTH];
  logic [7:0] rd_q;
  logic       hit;
  logic       in_range;

  assign in_range = {1'b0, rd_index} < DEPTH;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr[ADDR_W-1:0]] <= wr.data;
    end
    if (take && rd_en && in_range) begin
      rd_q <= mem[rd_index[ADDR_W-1:0]];
    end
  end

  // Hit follows every item so non-read items report zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (take) begin
      hit <= rd_en && in_range;
    end
  end

  assign rd_data = hit ? rd_q : 8'h00;

endmodule

// File: design/frp_parser.sv
// Frame parser: sync search, header capture, Fletcher sums, check and ready flag.
// Depends on frp_pkg.
`timescale 1ns / 1ps

module frp_parser #(
  parameter int PAYLOAD_DEPTH = frp_pkg::PAYLOAD_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              take,
  input  logic [1:0]                        kind,
  input  logic [7:0]                        rx_byte,
  input  logic                              cfg_we,
  input  logic [frp_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [frp_pkg::CFG_DATA_W-1:0]    cfg_data,
  output frp_pkg::frp_event_t               ev,
  output frp_pkg::frp_wr_t                  wr,
  output frp_pkg::frp_status_t              status
);

  localparam logic [8:0] DEPTH = 9'(PAYLOAD_DEPTH);

  logic [7:0]           first_sync;
  logic [7:0]           second_sync;
  frp_pkg::frp_phase_t  phase, phase_next;
  frp_pkg::frp_sums_t   sums, sums_next;
  frp_pkg::frp_sums_t   sums_add, sums_fresh;
  frp_pkg::frp_sums_t   base;
  logic [7:0]           count, count_next;
  logic [7:0]           count_inc;
  logic [7:0]           cls, cls_next;
  logic [7:0]           id, id_next;
  logic [7:0]           length, length_next;
  logic                 ready, ready_next;
  logic                 byte_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_sync  <= frp_pkg::FIRST_SYNC_RST;
      second_sync <= frp_pkg::SECOND_SYNC_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        frp_pkg::CFG_FIRST_SYNC:  first_sync  <= cfg_data;
        frp_pkg::CFG_SECOND_SYNC: second_sync <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= frp_pkg::PH_SYNC1;
      sums   <= '{hi: frp_pkg::SUM_BASE, lo: frp_pkg::SUM_BASE};
      count  <= 8'h00;
      cls    <= 8'h00;
      id     <= 8'h00;
      length <= 8'h00;
      ready  <= 1'b0;
    end else if (take) begin
      phase  <= phase_next;
      sums   <= sums_next;
      count  <= count_next;
      cls    <= cls_next;
      id     <= id_next;
      length <= length_next;
      ready  <= ready_next;
    end
  end

  assign base       = '{hi: frp_pkg::SUM_BASE, lo: frp_pkg::SUM_BASE};
  assign sums_add   = frp_pkg::frp_sum_step(sums, rx_byte);
  assign sums_fresh = frp_pkg::frp_sum_step(base, rx_byte);
  assign count_inc  = count + 8'd1;
  assign byte_item  = kind == frp_pkg::KIND_BYTE;

  always_comb begin
    phase_next  = phase;
    sums_next   = sums;
    count_next  = count;
    cls_next    = cls;
    id_next     = id;
    length_next = length;
    ready_next  = ready;
    ev          = frp_pkg::EV_NONE;
    wr.we       = 1'b0;
    wr.addr     = count;
    wr.data     = rx_byte;
    if (kind == frp_pkg::KIND_CLEAR) begin
      ready_next = 1'b0;
    end else if (byte_item) begin
      case (phase)
        frp_pkg::PH_SYNC1: begin
          if (rx_byte == first_sync) begin
            sums_next  = sums_add;
            phase_next = frp_pkg::PH_SYNC2;
          end
        end
        frp_pkg::PH_SYNC2: begin
          if (rx_byte == second_sync) begin
            sums_next  = sums_add;
            phase_next = frp_pkg::PH_CLASS;
          end else if (rx_byte == first_sync) begin
            // Repeated first sync: restart sums and keep waiting for second sync.
            sums_next  = sums_fresh;
            phase_next = frp_pkg::PH_SYNC2;
          end else begin
            sums_next  = base;
            phase_next = frp_pkg::PH_SYNC1;
          end
        end
        frp_pkg::PH_CLASS: begin
          cls_next   = rx_byte;
          sums_next  = sums_add;
          phase_next = frp_pkg::PH_ID;
        end
        frp_pkg::PH_ID: begin
          id_next    = rx_byte;
          sums_next  = sums_add;
          phase_next = frp_pkg::PH_LENGTH;
        end
        frp_pkg::PH_LENGTH: begin
          length_next = rx_byte;
          sums_next   = sums_add;
          phase_next  = (rx_byte == 8'h00) ? frp_pkg::PH_CHECK1 : frp_pkg::PH_PAYLOAD;
        end
        frp_pkg::PH_PAYLOAD: begin
          // Bytes past the store depth are summed only.
          wr.we      = {1'b0, count} < DEPTH;
          sums_next  = sums_add;
          count_next = count_inc;
          if (count_inc == length) begin
            count_next = 8'h00;
            phase_next = frp_pkg::PH_CHECK1;
          end
        end
        frp_pkg::PH_CHECK1: begin
          if (rx_byte == sums.lo) begin
            phase_next = frp_pkg::PH_CHECK2;
          end else begin
            sums_next  = base;
            phase_next = frp_pkg::PH_SYNC1;
            ev         = frp_pkg::EV_REJECT;
          end
        end
        default: begin
          if (rx_byte == sums.hi) begin
            ready_next = 1'b1;
            ev         = frp_pkg::EV_ACCEPT;
          end else begin
            ev = frp_pkg::EV_REJECT;
          end
          sums_next  = base;
          phase_next = frp_pkg::PH_SYNC1;
        end
      endcase
    end
    wr.we = wr.we && take;
  end

  assign status.ready  = ready;
  assign status.cls    = cls;
  assign status.id     = id;
  assign status.length = length;

endmodule

// File: tb/tb_framed_packet_receiver_unit.sv
// Testbench for framed_packet_receiver_unit: directed rows, then random frame traffic.
// Depends on frp_pkg, the frp_req_if / frp_rsp_if channels and the unit itself.
`timescale 1ns / 1ps

module tb_framed_packet_receiver_unit;
  import frp_pkg::*;

  localparam int STORE_DEPTH = PAYLOAD_DEPTH_DEF;
  localparam int DIR_ROWS = 25;
  localparam int ITEMS_PER_SYNC_PAIR = 385;
  localparam int SYNC_PAIRS = 5;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_AFTER = 500;
  localparam int LONG_HOLD = 400;
  localparam int QUIET_LIMIT = 2000;
  localparam int CHECK_COPY = 0;
  localparam int STIM_COPY = 1;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef enum int {FLAW_NONE, FLAW_BAD_LOW, FLAW_BAD_HIGH, FLAW_RESYNC, FLAW_CUT} frame_flaw_t;
  typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_PATTERN} sink_mode_t;

  typedef struct packed {
    frp_event_t ev;
    logic       flag;
    logic [7:0] cls;
    logic [7:0] id;
    logic [7:0] len;
    logic [7:0] rd;
  } frame_result_t;

  typedef struct packed {
    logic [1:0]    kind;
    logic [7:0]    rx;
    logic [7:0]    idx;
    logic          typed;
    frame_result_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  frp_req_if req_ch ();
  frp_rsp_if rsp_ch ();

  framed_packet_receiver_unit u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Two copies of the parser: one follows accepted items, one plans the stimulus.
  frp_phase_t phase_st [2];
  logic [7:0] sync_a [2];
  logic [7:0] sync_b [2];
  logic [7:0] lo_sum [2];
  logic [7:0] hi_sum [2];
  logic [7:0] held_cls [2];
  logic [7:0] held_id [2];
  logic [7:0] held_len [2];
  logic [7:0] pay_cnt [2];
  logic       ready_st [2];
  logic [7:0] pay_mem [2][STORE_DEPTH];
  int         fill [2];

  dir_row_t      dir_rows [DIR_ROWS];
  frame_result_t result_q [$];
  int items_sent;
  int items_taken;
  int results_checked;
  int mismatches;
  int frames_ok;
  int frames_bad;
  int reads_done;
  int burst_left;
  int quiet_cycles;

  function automatic void parser_reset(int m);
    phase_st[m] = PH_SYNC1;
    sync_a[m] = FIRST_SYNC_RST;
    sync_b[m] = SECOND_SYNC_RST;
    lo_sum[m] = 8'hFF;
    hi_sum[m] = 8'hFF;
    held_cls[m] = 8'h00;
    held_id[m] = 8'h00;
    held_len[m] = 8'h00;
    pay_cnt[m] = 8'h00;
    ready_st[m] = 1'b0;
    fill[m] = 0;
  endfunction

  function automatic void sums_restart(int m);
    lo_sum[m] = 8'hFF;
    hi_sum[m] = 8'hFF;
  endfunction

  // Fold each running sum back by 255 once it passes 255.
  function automatic void fletcher_add(int m, logic [7:0] b);
    logic [8:0] acc_lo;
    logic [8:0] acc_hi;
    acc_lo = {1'b0, lo_sum[m]} + {1'b0, b};
    if (acc_lo > 9'd255) acc_lo = acc_lo - 9'd255;
    acc_hi = {1'b0, hi_sum[m]} + acc_lo;
    if (acc_hi > 9'd255) acc_hi = acc_hi - 9'd255;
    lo_sum[m] = acc_lo[7:0];
    hi_sum[m] = acc_hi[7:0];
  endfunction

  function automatic frp_event_t parse_byte(int m, logic [7:0] b);
    frp_event_t ev;
    ev = EV_NONE;
    case (phase_st[m])
      PH_SYNC1: begin
        if (b == sync_a[m]) begin
          fletcher_add(m, b);
          phase_st[m] = PH_SYNC2;
        end
      end
      PH_SYNC2: begin
        if (b == sync_b[m]) begin
          fletcher_add(m, b);
          phase_st[m] = PH_CLASS;
        end else if (b == sync_a[m]) begin
          sums_restart(m);
          fletcher_add(m, b);
        end else begin
          sums_restart(m);
          phase_st[m] = PH_SYNC1;
        end
      end
      PH_CLASS: begin
        held_cls[m] = b;
        fletcher_add(m, b);
        phase_st[m] = PH_ID;
      end
      PH_ID: begin
        held_id[m] = b;
        fletcher_add(m, b);
        phase_st[m] = PH_LENGTH;
      end
      PH_LENGTH: begin
        held_len[m] = b;
        fletcher_add(m, b);
        phase_st[m] = (b == 8'd0) ? PH_CHECK1 : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        if (int'(pay_cnt[m]) < STORE_DEPTH) begin
          pay_mem[m][pay_cnt[m]] = b;
          if (fill[m] <= int'(pay_cnt[m])) fill[m] = int'(pay_cnt[m]) + 1;
        end
        fletcher_add(m, b);
        pay_cnt[m] = pay_cnt[m] + 8'd1;
        if (pay_cnt[m] == held_len[m]) begin
          pay_cnt[m] = 8'd0;
          phase_st[m] = PH_CHECK1;
        end
      end
      PH_CHECK1: begin
        if (b == lo_sum[m]) begin
          phase_st[m] = PH_CHECK2;
        end else begin
          sums_restart(m);
          phase_st[m] = PH_SYNC1;
          ev = EV_REJECT;
        end
      end
      default: begin
        if (b == hi_sum[m]) begin
          ready_st[m] = 1'b1;
          ev = EV_ACCEPT;
        end else begin
          ev = EV_REJECT;
        end
        sums_restart(m);
        phase_st[m] = PH_SYNC1;
      end
    endcase
    return ev;
  endfunction

  function automatic frame_result_t apply_item(int m, logic [1:0] k, logic [7:0] b,
                                               logic [7:0] ix);
    frame_result_t r;
    r = '0;
    case (k)
      KIND_BYTE: r.ev = parse_byte(m, b);
      KIND_READ: if (int'(ix) < STORE_DEPTH) r.rd = pay_mem[m][ix];
      KIND_CLEAR: ready_st[m] = 1'b0;
      default: ;
    endcase
    r.flag = ready_st[m];
    r.cls = held_cls[m];
    r.id = held_id[m];
    r.len = held_len[m];
    return r;
  endfunction

  // ---------------------------------------------------------------- sender

  task automatic send_item(logic [1:0] k, logic [7:0] b, logic [7:0] ix);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(7) == 0) begin
        gap = 0;
        burst_left = $urandom_range(300, 100);
      end else begin
        gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
        burst_left = $urandom_range(32, 1);
      end
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    req_ch.valid <= 1'b1;
    req_ch.kind <= k;
    req_ch.rx_byte <= b;
    req_ch.read_index <= ix;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic issue(logic [1:0] k, logic [7:0] b, logic [7:0] ix);
    void'(apply_item(STIM_COPY, k, b, ix));
    items_sent++;
    send_item(k, b, ix);
  endtask

  task automatic send_byte(logic [7:0] b);
    issue(KIND_BYTE, b, 8'($urandom));
  endtask

  // Reads only hit offsets that some frame has already written.
  task automatic side_item();
    int pick;
    logic [7:0] ix;
    pick = $urandom_range(9);
    if (pick < 6 && fill[STIM_COPY] > 0) begin
      if ($urandom_range(3) == 0) ix = 8'(fill[STIM_COPY] - 1);
      else ix = 8'($urandom_range(fill[STIM_COPY] - 1));
      issue(KIND_READ, 8'($urandom), ix);
    end else if (pick < 9) begin
      issue(KIND_CLEAR, 8'($urandom), 8'($urandom));
    end else begin
      issue(KIND_UNUSED, 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic maybe_side_item();
    if ($urandom_range(99) < 10) side_item();
  endtask

  // Push the planned parser back to the first sync phase with the cheapest bytes.
  task automatic drain_parser();
    logic [7:0] fb;
    while (phase_st[STIM_COPY] != PH_SYNC1) begin
      case (phase_st[STIM_COPY])
        PH_SYNC2: begin
          do fb = 8'($urandom);
          while (fb == sync_a[STIM_COPY] || fb == sync_b[STIM_COPY]);
        end
        PH_LENGTH: fb = 8'h00;
        PH_CHECK1: fb = lo_sum[STIM_COPY] ^ 8'h01;
        default: fb = 8'($urandom);
      endcase
      send_byte(fb);
    end
  endtask

  task automatic send_frame(int len, frame_flaw_t flaw);
    logic [7:0] body [$];
    logic [7:0] ck;
    int keep;
    drain_parser();
    if (flaw == FLAW_RESYNC && sync_a[STIM_COPY] != sync_b[STIM_COPY]) begin
      repeat ($urandom_range(2, 1)) body.push_back(sync_a[STIM_COPY]);
    end
    body.push_back(sync_a[STIM_COPY]);
    body.push_back(sync_b[STIM_COPY]);
    body.push_back(8'($urandom));
    body.push_back(8'($urandom));
    body.push_back(8'(len));
    for (int i = 0; i < len; i++) body.push_back(8'($urandom));
    if (flaw == FLAW_CUT) begin
      keep = $urandom_range(body.size() - 1, 1);
      while (body.size() > keep) void'(body.pop_back());
    end
    foreach (body[i]) begin
      maybe_side_item();
      send_byte(body[i]);
    end
    if (flaw == FLAW_CUT) return;
    maybe_side_item();
    ck = lo_sum[STIM_COPY];
    if (flaw == FLAW_BAD_LOW) ck = ck ^ 8'($urandom_range(255, 1));
    send_byte(ck);
    if (flaw == FLAW_BAD_LOW) return;
    maybe_side_item();
    ck = hi_sum[STIM_COPY];
    if (flaw == FLAW_BAD_HIGH) ck = ck ^ 8'($urandom_range(255, 1));
    send_byte(ck);
  endtask

  task automatic send_noise();
    repeat ($urandom_range(8, 1)) begin
      if ($urandom_range(3) == 0) send_byte(sync_a[STIM_COPY]);
      else send_byte(8'($urandom));
    end
  endtask

  function automatic int frame_len();
    int pick;
    pick = $urandom_range(99);
    if (pick < 5) return 0;
    if (pick < 85) return $urandom_range(12, 1);
    if (pick < 98) return $urandom_range(60, 13);
    return $urandom_range(255, 200);
  endfunction

  task automatic run_traffic(int upto);
    int pick;
    while (items_sent < upto) begin
      pick = $urandom_range(99);
      if (pick < 62) send_frame(frame_len(), FLAW_NONE);
      else if (pick < 70) send_frame(frame_len(), FLAW_BAD_LOW);
      else if (pick < 78) send_frame(frame_len(), FLAW_BAD_HIGH);
      else if (pick < 86) send_frame(frame_len(), FLAW_RESYNC);
      else if (pick < 93) send_frame(frame_len(), FLAW_CUT);
      else send_noise();
    end
  endtask

  task automatic set_sync(logic [7:0] a, logic [7:0] b);
    cfg_we <= 1'b1;
    cfg_index <= CFG_FIRST_SYNC;
    cfg_data <= a;
    @(negedge clk);
    cfg_index <= CFG_SECOND_SYNC;
    cfg_data <= b;
    @(negedge clk);
    cfg_we <= 1'b0;
    sync_a[STIM_COPY] = a;
    sync_b[STIM_COPY] = b;
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin : stimulus
    logic [7:0] pair_a;
    logic [7:0] pair_b;
    dir_rows = '{
      '{KIND_CLEAR,  8'h00, 8'h00, 1'b1, '{EV_NONE, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00}},
      '{KIND_UNUSED, 8'hFF, 8'hFF, 1'b1, '{EV_NONE, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00}},
      '{KIND_BYTE,   8'h00, 8'h00, 1'b1, '{EV_NONE, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00}},
      // wrong second sync byte falls back to hunting
      '{KIND_BYTE,   8'hC2, 8'h00, 1'b0, '0},
      '{KIND_BYTE,   8'h00, 8'h00, 1'b0, '0},
      // repeated first sync byte, then a three byte payload
      '{KIND_BYTE,   8'hC2, 8'h00, 1'b0, '0},
      '{KIND_BYTE,   8'hC2, 8'h00, 1'b0, '0},
      '{KIND_BYTE,   8'h53, 8'h00, 1'b0, '0},
      '{KIND_BYTE,   8'h10, 8'h00, 1'b0, '0},
      '{KIND_BYTE,   8'h20, 8'h00, 1'b0, '0},
      '{KIND_BYTE,   8'h03, 8'h00, 1'b0, '0},
      '{KIND_BYTE,   8'hAA, 8'h00, 1'b0, '0},
      '{KIND_BYTE,   8'hBB, 8'h00, 1'b0, '0},
      '{KIND_BYTE,   8'hCC, 8'h00, 1'b0, '0},
      '{KIND_BYTE,   8'h7C, 8'h00, 1'b0, '0},
      '{KIND_BYTE,   8'hAE, 8'h00, 1'b1, '{EV_ACCEPT, 1'b1, 8'h10, 8'h20, 8'h03, 8'h00}},
      '{KIND_READ,   8'h00, 8'h00, 1'b1, '{EV_NONE, 1'b1, 8'h10, 8'h20, 8'h03, 8'hAA}},
      '{KIND_READ,   8'h00, 8'h02, 1'b1, '{EV_NONE, 1'b1, 8'h10, 8'h20, 8'h03, 8'hCC}},
      '{KIND_CLEAR,  8'h00, 8'h00, 1'b1, '{EV_NONE, 1'b0, 8'h10, 8'h20, 8'h03, 8'h00}},
      // zero length frame with a bad low check byte
      '{KIND_BYTE,   8'hC2, 8'h00, 1'b0, '0},
      '{KIND_BYTE,   8'h53, 8'h00, 1'b0, '0},
      '{KIND_BYTE,   8'h01, 8'h00, 1'b0, '0},
      '{KIND_BYTE,   8'h02, 8'h00, 1'b0, '0},
      '{KIND_BYTE,   8'h00, 8'h00, 1'b0, '0},
      '{KIND_BYTE,   8'h18, 8'h00, 1'b1, '{EV_REJECT, 1'b0, 8'h01, 8'h02, 8'h00, 8'h00}}
    };
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_FIRST_SYNC;
    cfg_data = 8'h00;
    req_ch.valid = 1'b0;
    req_ch.kind = KIND_BYTE;
    req_ch.rx_byte = 8'h00;
    req_ch.read_index = 8'h00;
    parser_reset(CHECK_COPY);
    parser_reset(STIM_COPY);
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_sync(FIRST_SYNC_RST, SECOND_SYNC_RST);
    for (int i = 0; i < DIR_ROWS; i++) issue(dir_rows[i].kind, dir_rows[i].rx, dir_rows[i].idx);
    // fill store offsets 0 to 254 once so reads can reach each of them
    send_frame(255, FLAW_NONE);
    run_traffic(DIR_ROWS + ITEMS_PER_SYNC_PAIR);
    wait_drained();

    for (int p = 1; p < SYNC_PAIRS; p++) begin
      case (p)
        1: begin pair_a = 8'h00; pair_b = 8'hFF; end
        2: begin pair_a = 8'hFF; pair_b = 8'h00; end
        3: begin pair_a = 8'($urandom); pair_b = pair_a; end
        default: begin pair_a = 8'($urandom); pair_b = 8'($urandom); end
      endcase
      set_sync(pair_a, pair_b);
      run_traffic(DIR_ROWS + (p + 1) * ITEMS_PER_SYNC_PAIR);
      wait_drained();
    end

    $display("Checked %0d results over %0d sync byte pairs: %0d frames accepted, %0d rejected,",
             results_checked, SYNC_PAIRS, frames_ok, frames_bad);
    $display("%0d payload reads, one receiver hold-off of %0d cycles", reads_done, LONG_HOLD);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------- receiver

  initial begin : sink_side
    sink_mode_t mode;
    logic [7:0] stall_bits;
    bit long_hold_done;
    int cyc;
    rsp_ch.ready = 1'b0;
    mode = SINK_OPEN;
    stall_bits = 8'hFF;
    long_hold_done = 1'b0;
    cyc = 0;
    forever begin
      @(negedge clk);
      cyc++;
      // hold off long enough for the result register to back up into the input
      if (!long_hold_done && results_checked >= HOLD_AFTER) begin
        long_hold_done = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      if (cyc % 128 == 0) begin
        mode = sink_mode_t'($urandom_range(3));
        stall_bits = 8'($urandom) | 8'h01;
      end
      case (mode)
        SINK_OPEN: rsp_ch.ready <= 1'b1;
        SINK_COIN: rsp_ch.ready <= 1'($urandom_range(1));
        SINK_SPARSE: rsp_ch.ready <= ($urandom_range(3) == 0);
        default: rsp_ch.ready <= stall_bits[cyc % 8];
      endcase
    end
  end

  // ---------------------------------------------------------------- checking

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : monitor
    frame_result_t calc;
    frame_result_t want;
    if (!rst) begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FIRST_SYNC: sync_a[CHECK_COPY] = cfg_data;
          CFG_SECOND_SYNC: sync_b[CHECK_COPY] = cfg_data;
          default: ;
        endcase
      end
      if (req_ch.valid && req_ch.ready) begin
        calc = apply_item(CHECK_COPY, req_ch.kind, req_ch.rx_byte, req_ch.read_index);
        if (items_taken < DIR_ROWS && dir_rows[items_taken].typed)
          calc = dir_rows[items_taken].want;
        if (calc.ev == EV_ACCEPT) frames_ok++;
        if (calc.ev == EV_REJECT) frames_bad++;
        if (req_ch.kind == KIND_READ) reads_done++;
        result_q.push_back(calc);
        items_taken++;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (result_q.size() == 0) begin
          $error("result arrived with no item outstanding");
          mismatches++;
        end else begin
          want = result_q.pop_front();
          check_field("frame_event", int'(want.ev), int'(rsp_ch.frame_event));
          check_field("frame_ready", int'(want.flag), int'(rsp_ch.frame_ready));
          check_field("frame_class", int'(want.cls), int'(rsp_ch.frame_class));
          check_field("frame_id", int'(want.id), int'(rsp_ch.frame_id));
          check_field("frame_length", int'(want.len), int'(rsp_ch.frame_length));
          check_field("read_data", int'(want.rd), int'(rsp_ch.read_data));
        end
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $error("no item moved for %0d cycles, %0d results outstanding",
             quiet_cycles, result_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule
